[rtl/core/bpfm_pkg.sv]
// ----------------------------------------------------------------------------
// bpfm_pkg
// shared types, codes and sizes for the buffer pool frame manager
// ----------------------------------------------------------------------------
package bpfm_pkg;

  localparam int unsigned NUM_FRAMES_DEF = 64;
  localparam int unsigned PIN_BITS_DEF   = 16;

  localparam logic [1:0] MODE_FETCH = 2'd0;
  localparam logic [1:0] MODE_UNPIN = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_MISS       = 3'd1;
  localparam logic [2:0] ST_NO_FRAME   = 3'd2;
  localparam logic [2:0] ST_NOT_RES    = 3'd3;
  localparam logic [2:0] ST_NOT_PINNED = 3'd4;
  localparam logic [2:0] ST_DONE       = 3'd5;
  localparam logic [2:0] ST_SATURATED  = 3'd6;

  typedef struct packed {
    logic start;
    logic commit;
  } bpfm_cmd_t;

  typedef struct packed {
    logic search_done;
  } bpfm_stat_t;

endpackage

[rtl/core/bpfm_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfm_ctrl
// request sequencer: accept, search, commit, present result
// ----------------------------------------------------------------------------
module bpfm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bpfm_pkg::bpfm_cmd_t  cmd,
  input  bpfm_pkg::bpfm_stat_t stat
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign ready     = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cmd.start  = valid && ready;
  assign cmd.commit = (state == S_COMMIT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (valid) state_next = S_SEARCH;
      S_SEARCH: if (stat.search_done) state_next = S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

[rtl/core/bpfm_dp.sv]
// ----------------------------------------------------------------------------
// bpfm_dp
// frame metadata, serial tag and free-frame search, lru list and result
// ----------------------------------------------------------------------------
module bpfm_dp #(
  parameter int unsigned NUM_FRAMES = bpfm_pkg::NUM_FRAMES_DEF,
  parameter int unsigned PIN_BITS   = bpfm_pkg::PIN_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bpfm_pkg::bpfm_cmd_t  cmd,
  output bpfm_pkg::bpfm_stat_t stat,
  input  logic [1:0]           mode,
  input  logic [15:0]          file_id,
  input  logic [31:0]          page_number,
  input  logic                 mark_dirty,
  output logic [2:0]           status,
  output logic [5:0]           frame,
  output logic                 load_valid,
  output logic                 writeback_valid,
  output logic [15:0]          writeback_file,
  output logic [31:0]          writeback_page
);

  localparam int unsigned FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int unsigned CW = $clog2(NUM_FRAMES + 1);
  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  logic [NUM_FRAMES-1:0] resident;
  logic [NUM_FRAMES-1:0] modified;
  logic [PIN_BITS-1:0]   pins [NUM_FRAMES];
  logic [47:0]           tags [NUM_FRAMES];
  // lru list kept as a rank per frame, lowest is oldest; a gap closes during the next scan
  logic [NUM_FRAMES-1:0] in_lru;
  logic [FW-1:0]         rank [NUM_FRAMES];
  logic [CW-1:0]         lru_count;
  logic                  rm_pend;
  logic [FW-1:0]         rm_rank;

  logic [1:0]  r_mode;
  logic [47:0] r_tag;
  logic        r_dirty;
  logic [FW-1:0] addr, s1;
  logic          rd_on, s1_on;
  logic [47:0]         tag_q;
  logic [PIN_BITS-1:0] pin_q;
  logic [FW-1:0]       rank_q, rank_adj;
  logic          hit_f, free_f, lru_f;
  logic [FW-1:0] hit_i, free_i, lru_i;
  logic [FW-1:0] hit_rank, lru_r;
  logic [PIN_BITS-1:0] hit_pins;
  logic [47:0]   lru_tag;
  logic          fix_we, do_hit_pin, do_claim, do_unpin, do_push;

  logic [FW-1:0] last;
  assign last = FW'(NUM_FRAMES - 1);

  assign rank_adj = (rm_pend && rank_q > rm_rank) ? rank_q - 1'b1 : rank_q;
  assign fix_we   = s1_on && in_lru[s1] && rm_pend && (rank_q > rm_rank);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_on <= 1'b0;
      s1_on <= 1'b0;
    end else if (cmd.start) begin
      rd_on <= 1'b1;
      s1_on <= 1'b0;
    end else begin
      s1_on <= rd_on;
      if (rd_on && addr == last) rd_on <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_mode  <= mode;
      r_tag   <= {file_id, page_number};
      r_dirty <= mark_dirty;
      addr    <= '0;
      hit_f   <= 1'b0;
      free_f  <= 1'b0;
      lru_f   <= 1'b0;
    end else begin
      s1 <= addr;
      if (rd_on && addr != last) addr <= addr + 1'b1;
      if (s1_on) begin
        if (!hit_f && resident[s1] && tag_q == r_tag) begin
          hit_f    <= 1'b1;
          hit_i    <= s1;
          hit_pins <= pin_q;
          hit_rank <= rank_adj;
        end
        if (!free_f && !resident[s1]) begin
          free_f <= 1'b1;
          free_i <= s1;
        end
        if (in_lru[s1] && (!lru_f || rank_adj < lru_r)) begin
          lru_f   <= 1'b1;
          lru_i   <= s1;
          lru_r   <= rank_adj;
          lru_tag <= tag_q;
        end
      end
    end
  end

  logic scan_end;
  always_ff @(posedge clk) begin
    if (rst || cmd.start) scan_end <= 1'b0;
    else if (s1_on && s1 == last) scan_end <= 1'b1;
  end
  assign stat.search_done = scan_end;

  logic [FW-1:0] vic;
  assign vic = free_f ? free_i : lru_i;

  always_comb begin
    do_hit_pin = 1'b0;
    do_claim   = 1'b0;
    do_unpin   = 1'b0;
    if (cmd.commit) begin
      case (r_mode)
        bpfm_pkg::MODE_FETCH: begin
          if (hit_f) do_hit_pin = (hit_pins != PIN_MAX);
          else do_claim = free_f || lru_f;
        end
        bpfm_pkg::MODE_UNPIN: do_unpin = hit_f && (hit_pins != '0);
        default: do_claim = 1'b0;
      endcase
    end
  end
  assign do_push = do_unpin && hit_pins == PIN_BITS'(1) && !in_lru[hit_i];

  always_ff @(posedge clk) begin
    if (do_claim) begin
      tags[vic] <= r_tag;
      pins[vic] <= PIN_BITS'(1);
    end
    if (do_hit_pin) pins[hit_i] <= hit_pins + 1'b1;
    if (do_unpin) pins[hit_i] <= hit_pins - 1'b1;
    if (do_push) rank[hit_i] <= lru_count[FW-1:0];
    else if (fix_we) rank[s1] <= rank_adj;
    tag_q  <= tags[addr];
    pin_q  <= pins[addr];
    rank_q <= rank[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resident  <= '0;
      modified  <= '0;
      in_lru    <= '0;
      lru_count <= '0;
      rm_pend   <= 1'b0;
    end else begin
      if (s1_on && s1 == last) rm_pend <= 1'b0;
      if (cmd.commit) begin
        status          <= bpfm_pkg::ST_DONE;
        frame           <= '0;
        load_valid      <= 1'b0;
        writeback_valid <= 1'b0;
        writeback_file  <= '0;
        writeback_page  <= '0;
        case (r_mode)
          bpfm_pkg::MODE_FETCH: begin
            if (hit_f) begin
              frame <= 6'(hit_i);
              if (hit_pins == PIN_MAX) status <= bpfm_pkg::ST_SATURATED;
              else status <= bpfm_pkg::ST_HIT;
              if (in_lru[hit_i]) begin
                in_lru[hit_i] <= 1'b0;
                rm_pend       <= 1'b1;
                rm_rank       <= hit_rank;
                lru_count     <= lru_count - 1'b1;
              end
            end else if (free_f || lru_f) begin
              if (resident[vic] && modified[vic]) begin
                writeback_valid <= 1'b1;
                writeback_file  <= lru_tag[47:32];
                writeback_page  <= lru_tag[31:0];
              end
              if (!free_f) begin
                in_lru[lru_i] <= 1'b0;
                rm_pend       <= 1'b1;
                rm_rank       <= lru_r;
                lru_count     <= lru_count - 1'b1;
              end
              resident[vic] <= 1'b1;
              modified[vic] <= 1'b0;
              status        <= bpfm_pkg::ST_MISS;
              load_valid    <= 1'b1;
              frame         <= 6'(vic);
            end else status <= bpfm_pkg::ST_NO_FRAME;
          end
          bpfm_pkg::MODE_UNPIN: begin
            if (!hit_f) status <= bpfm_pkg::ST_NOT_RES;
            else begin
              frame <= 6'(hit_i);
              if (hit_pins == '0) status <= bpfm_pkg::ST_NOT_PINNED;
              else begin
                if (do_push) begin
                  in_lru[hit_i] <= 1'b1;
                  lru_count     <= lru_count + 1'b1;
                end
                if (r_dirty) modified[hit_i] <= 1'b1;
              end
            end
          end
          bpfm_pkg::MODE_FLUSH: begin
            if (!hit_f) status <= bpfm_pkg::ST_NOT_RES;
            else begin
              frame           <= 6'(hit_i);
              writeback_valid <= 1'b1;
              writeback_file  <= r_tag[47:32];
              writeback_page  <= r_tag[31:0];
              modified[hit_i] <= 1'b0;
            end
          end
          default: status <= bpfm_pkg::ST_DONE;
        endcase
      end
    end
  end

endmodule

[rtl/core/buffer_pool_frame_manager.sv]
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// page-frame metadata manager with lru replacement
// ----------------------------------------------------------------------------
// the result follows a serial scan of all frames after accept, one frame read a cycle
// throughput: a new request is accepted only after the previous result is taken
// reset: all frames free, replacement list empty
module buffer_pool_frame_manager #(
  parameter int unsigned NUM_FRAMES = bpfm_pkg::NUM_FRAMES_DEF,
  parameter int unsigned PIN_BITS   = bpfm_pkg::PIN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  mode,
  input  logic [15:0] file_id,
  input  logic [31:0] page_number,
  input  logic        mark_dirty,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  frame,
  output logic        load_valid,
  output logic        writeback_valid,
  output logic [15:0] writeback_file,
  output logic [31:0] writeback_page
);

  bpfm_pkg::bpfm_cmd_t  cmd;
  bpfm_pkg::bpfm_stat_t stat;

  bpfm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .stat(stat)
  );

  bpfm_dp #(.NUM_FRAMES(NUM_FRAMES), .PIN_BITS(PIN_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .mode(mode), .file_id(file_id), .page_number(page_number),
    .mark_dirty(mark_dirty), .status(status), .frame(frame),
    .load_valid(load_valid), .writeback_valid(writeback_valid),
    .writeback_file(writeback_file), .writeback_page(writeback_page)
  );

endmodule
